// ----- rtl/sobel_pkg.sv -----
// ----------------------------------------------------------------------------
// sobel_pkg
// Shared constants and types for the Sobel edge magnitude block.
// ----------------------------------------------------------------------------
package sobel_pkg;

    localparam int DEFAULT_MAX_WIDTH = 2048;
    localparam int PIX_W             = 24;
    localparam int CFG_AW            = 3;

    localparam logic [CFG_AW-1:0] ADDR_WIDTH  = 3'd0;
    localparam logic [CFG_AW-1:0] ADDR_HEIGHT = 3'd4;

    localparam logic [11:0] RESET_WIDTH  = 12'd640;
    localparam logic [15:0] RESET_HEIGHT = 16'd480;

    // one root stage hands this word to the next
    typedef struct packed {
        logic        valid;
        logic        eof;
        logic [16:0] rem0;
        logic [16:0] rem1;
        logic [16:0] rem2;
        logic [7:0]  res0;
        logic [7:0]  res1;
        logic [7:0]  res2;
        logic        sat0;
        logic        sat1;
        logic        sat2;
    } root_word_t;

endpackage

// ----- rtl/sobel_root_cell.sv -----
// ----------------------------------------------------------------------------
// sobel_root_cell
// One bit of a restoring square root for all three channels, registered.
// ----------------------------------------------------------------------------
module sobel_root_cell
#(
    parameter int BIT = 7
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  sobel_pkg::root_word_t din,
    output sobel_pkg::root_word_t dout
);
    import sobel_pkg::*;

    root_word_t word_reg;
    root_word_t word_next;

    // s kept as remainder s - res^2; try t = res | bit
    function automatic void step(input logic [16:0] rem, input logic [7:0] res,
                                 output logic [16:0] rem_o, output logic [7:0] res_o);
        logic [17:0] trial;
        trial = ({10'd0, res} << (BIT + 1)) + (18'd1 << (2 * BIT));
        if ({1'b0, rem} >= trial)
        begin
            rem_o = rem - trial[16:0];
            res_o = res | (8'd1 << BIT);
        end
        else
        begin
            rem_o = rem;
            res_o = res;
        end
    endfunction

    always_comb
    begin
        word_next = din;
        step(din.rem0, din.res0, word_next.rem0, word_next.res0);
        step(din.rem1, din.res1, word_next.rem1, word_next.res1);
        step(din.rem2, din.res2, word_next.rem2, word_next.res2);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            word_reg <= '0;
        else
            word_reg <= word_next;
    end

    assign dout = word_reg;

endmodule

// ----- rtl/sobel_edge_magnitude.sv -----
// ----------------------------------------------------------------------------
// sobel_edge_magnitude
// Pipeline: a result word passes the line-store read, gradient and square-sum
// registers, then eight root cells driving the outputs.
// Throughput: one word per cycle while the output side is not stalled; any
// stall holds the whole chain of root cells.
// Reset clears counters, window and pipeline; line stores are not cleared.
// ----------------------------------------------------------------------------
module sobel_edge_magnitude
#(
    parameter int MAX_WIDTH = sobel_pkg::DEFAULT_MAX_WIDTH
)
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [sobel_pkg::CFG_AW-1:0] paddr,
    input  logic [31:0]                  pwdata,
    output logic [31:0]                  prdata,
    output logic                         pready,
    input  logic                         in_valid,
    output logic                         in_stall,
    input  logic                         mode,
    input  logic [7:0]                   red_sample,
    input  logic [7:0]                   green_sample,
    input  logic [7:0]                   blue_sample,
    output logic                         out_valid,
    input  logic                         out_stall,
    output logic [7:0]                   red_edge,
    output logic [7:0]                   green_edge,
    output logic [7:0]                   blue_edge,
    output logic                         end_of_frame
);
    import sobel_pkg::*;

    localparam int CW = $clog2(MAX_WIDTH);
    localparam int NS = 8;

    logic [11:0] width_reg;
    logic [15:0] height_reg;
    logic        cfg_wr;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;
    always_comb
    begin
        case (paddr)
            ADDR_WIDTH:  prdata = {20'd0, width_reg};
            ADDR_HEIGHT: prdata = {16'd0, height_reg};
            default:     prdata = 32'd0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= RESET_WIDTH;
            height_reg <= RESET_HEIGHT;
        end
        else if (cfg_wr && paddr == ADDR_WIDTH)
            width_reg <= pwdata[11:0];
        else if (cfg_wr && paddr == ADDR_HEIGHT)
            height_reg <= pwdata[15:0];
    end

    // effective sizes
    logic [CW:0]  w_eff;
    logic [15:0]  h_eff;
    always_comb
    begin
        if ({20'd0, width_reg} < 32'd3)
            w_eff = (CW+1)'(3);
        else if ({20'd0, width_reg} > 32'(MAX_WIDTH))
            w_eff = (CW+1)'(MAX_WIDTH);
        else
            w_eff = (CW+1)'(width_reg);
        h_eff = (height_reg == 16'd0) ? 16'd1 : height_reg;
    end

    // the whole pipeline advances together
    logic adv;
    assign adv      = !out_stall || !out_valid;
    assign in_stall = !adv;
    logic acc;
    assign acc = in_valid && adv;

    // stage 0: counters, line stores read
    logic [CW-1:0] col_reg, col_next;
    logic [16:0]   row_reg, row_next;
    logic [PIX_W-1:0] la_mem [MAX_WIDTH];
    logic [PIX_W-1:0] lb_mem [MAX_WIDTH];
    logic [PIX_W-1:0] pix;
    logic [CW:0]   col_c;
    logic          emit;
    logic [CW:0]   oc;
    logic [16:0]   orow;
    logic          eof_c;

    assign pix   = mode ? '0 : {blue_sample, green_sample, red_sample};
    assign col_c = ({1'b0, col_reg} >= w_eff) ? '0 : {1'b0, col_reg};
    assign emit  = (row_reg >= 17'd2) || (row_reg == 17'd1 && col_c != '0);
    assign oc    = (col_c == '0) ? w_eff - 1'b1 : col_c - 1'b1;
    assign orow  = (col_c == '0) ? row_reg - 17'd2 : row_reg - 17'd1;
    assign eof_c = emit && oc == w_eff - 1'b1 && orow == {1'b0, h_eff} - 17'd1;

    always_comb
    begin
        logic [CW:0] c1;
        c1 = col_c + 1'b1;
        if (eof_c)
        begin
            col_next = '0;
            row_next = '0;
        end
        else if (c1 >= w_eff)
        begin
            col_next = '0;
            row_next = row_reg + 17'd1;
        end
        else
        begin
            col_next = c1[CW-1:0];
            row_next = row_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg <= '0;
            row_reg <= '0;
        end
        else if (cfg_wr && (paddr == ADDR_WIDTH || paddr == ADDR_HEIGHT))
        begin
            col_reg <= '0;
            row_reg <= '0;
        end
        else if (acc)
        begin
            col_reg <= col_next;
            row_reg <= row_next;
        end
    end

    logic [PIX_W-1:0] top_reg, mid_reg, pix_reg;
    always_ff @(posedge clk)
    begin
        if (acc)
        begin
            top_reg <= lb_mem[col_c[CW-1:0]];
            mid_reg <= la_mem[col_c[CW-1:0]];
            lb_mem[col_c[CW-1:0]] <= la_mem[col_c[CW-1:0]];
            la_mem[col_c[CW-1:0]] <= pix;
        end
    end

    // stage 1 control: window shift and masks
    logic        v1_reg, eof1_reg, emit1_reg;
    logic [8:0]  msk1_reg;
    logic [8:0]  msk;
    always_comb
    begin
        logic [1:0] k;
        for (int i = 0; i < 9; i++)
        begin
            k = 2'(i % 3);
            msk[i] = 1'b1;
            if (k == 2'd0 && oc == '0) msk[i] = 1'b0;
            if (k == 2'd2 && oc == w_eff - 1'b1) msk[i] = 1'b0;
            if (i < 3 && orow == '0) msk[i] = 1'b0;
            if (i >= 6 && orow == {1'b0, h_eff} - 17'd1) msk[i] = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg   <= 1'b0;
        end
        else if (adv)
            v1_reg <= acc;
    end
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            emit1_reg <= emit && acc;
            eof1_reg  <= eof_c;
            msk1_reg  <= msk;
        end
    end

    // window: column shift happens once the new column lands (stage 1)
    logic [PIX_W-1:0] win_reg [9];
    logic [PIX_W-1:0] wv [9];
    always_comb
    begin
        // window as seen by this pixel
        wv[0] = win_reg[1]; wv[1] = win_reg[2]; wv[2] = top_reg;
        wv[3] = win_reg[4]; wv[4] = win_reg[5]; wv[5] = mid_reg;
        wv[6] = win_reg[7]; wv[7] = win_reg[8]; wv[8] = pix_reg;
    end
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < 9; i++)
                win_reg[i] <= '0;
        end
        else if (adv && v1_reg)
        begin
            for (int i = 0; i < 9; i++)
                win_reg[i] <= wv[i];
        end
    end
    always_ff @(posedge clk)
    begin
        if (acc)
            pix_reg <= pix;
    end

    // stage 2: gradients
    logic        v2_reg, eof2_reg;
    logic signed [10:0] gx_reg [3];
    logic signed [10:0] gy_reg [3];
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v2_reg <= 1'b0;
        else if (adv)
            v2_reg <= v1_reg && emit1_reg;
    end
    always_ff @(posedge clk)
    begin
        logic signed [10:0] p [9];
        if (adv)
        begin
            eof2_reg <= eof1_reg;
            for (int c = 0; c < 3; c++)
            begin
                for (int i = 0; i < 9; i++)
                    p[i] = msk1_reg[i] ? $signed({3'd0, wv[i][8*c +: 8]}) : 11'sd0;
                gx_reg[c] <= (p[2] - p[0]) + ((p[5] - p[3]) <<< 1) + (p[8] - p[6]);
                gy_reg[c] <= (p[0] + (p[1] <<< 1) + p[2]) - (p[6] + (p[7] <<< 1) + p[8]);
            end
        end
    end

    // stage 3: squared sum, saturation flag
    root_word_t chain [NS+1];
    always_ff @(posedge clk or negedge rst_n)
    begin
        logic [20:0] s [3];
        if (!rst_n)
            chain[0] <= '0;
        else if (adv)
        begin
            chain[0].valid <= v2_reg;
            chain[0].eof   <= eof2_reg;
            for (int c = 0; c < 3; c++)
                s[c] = 21'(gx_reg[c] * gx_reg[c]) + 21'(gy_reg[c] * gy_reg[c]);
            chain[0].rem0 <= s[0][16:0];
            chain[0].rem1 <= s[1][16:0];
            chain[0].rem2 <= s[2][16:0];
            chain[0].sat0 <= s[0] >= 21'd65025;
            chain[0].sat1 <= s[1] >= 21'd65025;
            chain[0].sat2 <= s[2] >= 21'd65025;
            chain[0].res0 <= '0;
            chain[0].res1 <= '0;
            chain[0].res2 <= '0;
        end
    end

    // root cells: hold when stalled by feeding back own output
    root_word_t cell_in [NS];
    for (genvar g = 0; g < NS; g++)
    begin : g_root
        assign cell_in[g] = adv ? chain[g] : chain[g+1];
        sobel_root_cell #(.BIT(NS - 1 - g)) u_cell
        (
            .clk  (clk),
            .rst_n(rst_n),
            .din  (cell_in[g]),
            .dout (chain[g+1])
        );
    end

    // feedback on hold would re-run a bit; a held word is finished for that bit
    // so re-applying it is idempotent (res bit set: trial exceeds rem)
    assign out_valid    = chain[NS].valid;
    assign red_edge     = chain[NS].sat0 ? 8'd255 : chain[NS].res0;
    assign green_edge   = chain[NS].sat1 ? 8'd255 : chain[NS].res1;
    assign blue_edge    = chain[NS].sat2 ? 8'd255 : chain[NS].res2;
    assign end_of_frame = chain[NS].eof;

endmodule

// ----- dv/tb_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sobel edge magnitude testbench
// Streams frames of RGB words through the block with flush words after each
// frame, and checks every edge word against a software predictor. Idle and
// stall gaps are drawn at random on both sides.
// ----------------------------------------------------------------------------
module tb_top;
    import sobel_pkg::*;

    typedef struct packed {
        logic       mode;
        logic [7:0] r;
        logic [7:0] g;
        logic [7:0] b;
    } pix_word_t;

    typedef struct packed {
        logic [7:0] r;
        logic [7:0] g;
        logic [7:0] b;
        logic       eof;
    } edge_word_t;

    typedef enum int {PAT_ZERO, PAT_FULL, PAT_CHECKER, PAT_RANDOM} pattern_t;

    localparam int MAXW = DEFAULT_MAX_WIDTH;

    logic              clk;
    logic              rst_n;
    logic              psel;
    logic              penable;
    logic              pwrite;
    logic [CFG_AW-1:0] paddr;
    logic [31:0]       pwdata;
    logic [31:0]       prdata;
    logic              pready;
    logic              in_valid;
    logic              in_stall;
    logic              mode;
    logic [7:0]        red_sample;
    logic [7:0]        green_sample;
    logic [7:0]        blue_sample;
    logic              out_valid;
    logic              out_stall;
    logic [7:0]        red_edge;
    logic [7:0]        green_edge;
    logic [7:0]        blue_edge;
    logic              end_of_frame;

    sobel_edge_magnitude DUT (.*);

    // predictor state
    logic [11:0] cur_width;
    logic [15:0] cur_height;
    logic [23:0] row_prev [MAXW];
    logic [23:0] row_prev2 [MAXW];
    logic [23:0] win [9];
    int unsigned col_cnt;
    int unsigned row_cnt;

    pix_word_t  pending_words[$];
    edge_word_t expected_edges[$];
    int         errors;
    int         hold_off_cycles;
    int         in_gap;
    int         out_gap;
    logic       in_taken;

    function automatic int unsigned width_eff();
        if (cur_width < 3) return 3;
        if (cur_width > MAXW) return MAXW;
        return cur_width;
    endfunction

    function automatic int unsigned height_eff();
        return (cur_height == 0) ? 1 : cur_height;
    endfunction

    function automatic logic [7:0] sat_root(int unsigned s);
        int unsigned res;
        int unsigned t;
        res = 0;
        if (s >= 65025) return 8'd255;
        for (int bit_i = 7; bit_i >= 0; bit_i--)
        begin
            t = res | (1 << bit_i);
            if (t * t <= s) res = t;
        end
        return res[7:0];
    endfunction

    task automatic predict_edge(input pix_word_t w_in);
        int unsigned w, h, c, r;
        logic [23:0] px, top, mid;
        int oc, orow, nx, ny, gx, gy, v;
        logic [7:0] mag [3];
        edge_word_t e;
        w = width_eff();
        h = height_eff();
        c = col_cnt;
        r = row_cnt;
        if (c >= w) c = 0;
        px = w_in.mode ? 24'd0 : {w_in.b, w_in.g, w_in.r};
        top = row_prev2[c];
        mid = row_prev[c];
        row_prev2[c] = mid;
        row_prev[c] = px;
        for (int i = 0; i < 3; i++)
        begin
            win[i*3] = win[i*3+1];
            win[i*3+1] = win[i*3+2];
        end
        win[2] = top;
        win[5] = mid;
        win[8] = px;
        if (r >= 2 || (r == 1 && c >= 1))
        begin
            if (c == 0)
            begin
                oc = w - 1;
                orow = r - 2;
            end
            else
            begin
                oc = c - 1;
                orow = r - 1;
            end
            for (int ch = 0; ch < 3; ch++)
            begin
                gx = 0;
                gy = 0;
                for (int k = 0; k < 9; k++)
                begin
                    nx = oc + (k % 3) - 1;
                    ny = orow + (k / 3) - 1;
                    if (nx < 0 || ny < 0 || nx >= int'(w) || ny >= int'(h)) continue;
                    v = (win[k] >> (8 * ch)) & 8'hFF;
                    // Sobel X columns -1,0,+1 weighted 1,2,1; Y rows +,0,-
                    gx += ((k % 3) - 1) * ((k / 3 == 1) ? 2 : 1) * v;
                    gy += (1 - (k / 3)) * ((k % 3 == 1) ? 2 : 1) * v;
                end
                mag[ch] = sat_root(gx * gx + gy * gy);
            end
            e.r = mag[0];
            e.g = mag[1];
            e.b = mag[2];
            e.eof = (oc == int'(w) - 1 && orow == int'(h) - 1);
            expected_edges.push_back(e);
            if (e.eof)
            begin
                col_cnt = 0;
                row_cnt = 0;
                return;
            end
        end
        c++;
        if (c >= w)
        begin
            c = 0;
            r++;
        end
        col_cnt = c;
        row_cnt = r & 17'h1FFFF;
    endtask

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    initial
    begin
        #50ms;
        $display("FAILURE");
        $finish;
    end

    // driver: predict on acceptance, then draw the next gap
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_gap <= 0;
            in_taken <= 1'b0;
        end
        else
        begin
            in_taken <= in_valid && !in_stall;
            if (in_valid && !in_stall)
            begin
                predict_edge(pending_words[0]);
                void'(pending_words.pop_front());
                in_gap <= $urandom_range(0, 3) == 0 ? $urandom_range(0, 12) : 0;
            end
            else if (!in_valid && in_gap > 0)
            begin
                in_gap <= in_gap - 1;
            end
        end
    end

    // hold a word until it is taken, then offer the next one
    always @(negedge clk)
    begin
        if (rst_n && (!in_valid || in_taken))
        begin
            if (pending_words.size() > 0 && in_gap == 0)
            begin
                in_valid <= 1'b1;
                {mode, red_sample, green_sample, blue_sample} <= pending_words[0];
            end
            else
            begin
                in_valid <= 1'b0;
            end
        end
    end

    // monitor
    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            if (expected_edges.size() == 0)
            begin
                $error("unexpected edge word");
                errors++;
            end
            else
            begin
                if (red_edge !== expected_edges[0].r)
                begin
                    $error("red_edge exp %0d got %0d", expected_edges[0].r, red_edge);
                    errors++;
                end
                if (green_edge !== expected_edges[0].g)
                begin
                    $error("green_edge exp %0d got %0d", expected_edges[0].g, green_edge);
                    errors++;
                end
                if (blue_edge !== expected_edges[0].b)
                begin
                    $error("blue_edge exp %0d got %0d", expected_edges[0].b, blue_edge);
                    errors++;
                end
                if (end_of_frame !== expected_edges[0].eof)
                begin
                    $error("end_of_frame exp %0d got %0d",
                           expected_edges[0].eof, end_of_frame);
                    errors++;
                end
                void'(expected_edges.pop_front());
            end
        end
    end

    always @(negedge clk)
    begin
        if (!rst_n)
        begin
            out_stall <= 1'b0;
            out_gap <= 0;
        end
        else if (hold_off_cycles > 0)
        begin
            out_stall <= 1'b1;
            hold_off_cycles <= hold_off_cycles - 1;
        end
        else if (out_gap > 0)
        begin
            out_stall <= 1'b1;
            out_gap <= out_gap - 1;
        end
        else
        begin
            out_stall <= 1'b0;
            if (out_valid && $urandom_range(0, 3) == 0) out_gap <= $urandom_range(0, 12);
        end
    end

    task automatic apb_write(input logic [CFG_AW-1:0] a, input logic [31:0] d);
        @(negedge clk);
        psel <= 1'b1;
        pwrite <= 1'b1;
        paddr <= a;
        pwdata <= d;
        @(negedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready) @(posedge clk);
        if (a == ADDR_WIDTH) cur_width = d[11:0];
        else cur_height = d[15:0];
        col_cnt = 0;
        row_cnt = 0;
        @(negedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
    endtask

    task automatic wait_idle();
        int guard;
        guard = 0;
        while ((pending_words.size() > 0 || expected_edges.size() > 0) && guard < 2000000)
        begin
            @(posedge clk);
            guard++;
        end
        repeat (30) @(posedge clk);
    endtask

    // queue a frame, plus flush words; noise turns pixels into flushes and flushes into pixels at random spots
    task automatic queue_frame(input int unsigned w, input int unsigned h, input bit noisy,
                               input pattern_t kind);
        pix_word_t p;
        for (int unsigned i = 0; i < w * h; i++)
        begin
            p.mode = noisy && ($urandom_range(0, 15) == 0);
            case (kind)
                PAT_ZERO:    {p.r, p.g, p.b} = 24'd0;
                PAT_FULL:    {p.r, p.g, p.b} = 24'hFFFFFF;
                PAT_CHECKER: {p.r, p.g, p.b} = ((i / w + i) % 2) ? 24'hFFFFFF : 24'd0;
                default:     {p.r, p.g, p.b} = 24'($urandom);
            endcase
            pending_words.push_back(p);
        end
        for (int unsigned i = 0; i < w + 1; i++)
        begin
            p.mode = !(noisy && $urandom_range(0, 7) == 0);
            {p.r, p.g, p.b} = 24'($urandom);
            pending_words.push_back(p);
        end
    endtask

    initial
    begin
        int unsigned w, h;
        errors = 0;
        hold_off_cycles = 0;
        cur_width = RESET_WIDTH;
        cur_height = RESET_HEIGHT;
        col_cnt = 0;
        row_cnt = 0;
        for (int i = 0; i < MAXW; i++)
        begin
            row_prev[i] = '0;
            row_prev2[i] = '0;
        end
        for (int i = 0; i < 9; i++) win[i] = '0;
        rst_n = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        in_valid = 1'b0;
        mode = 1'b0;
        red_sample = '0;
        green_sample = '0;
        blue_sample = '0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;

        // directed: smallest width, extremes and a checkerboard
        apb_write(ADDR_WIDTH, 32'd3);
        apb_write(ADDR_HEIGHT, 32'd1);
        queue_frame(3, 1, 0, PAT_FULL);
        wait_idle();
        apb_write(ADDR_HEIGHT, 32'd3);
        queue_frame(3, 3, 0, PAT_CHECKER);
        queue_frame(3, 3, 0, PAT_ZERO);
        wait_idle();
        // out-of-range settings saturate
        apb_write(ADDR_WIDTH, 32'd0);
        apb_write(ADDR_HEIGHT, 32'd0);
        queue_frame(3, 1, 1, PAT_RANDOM);
        wait_idle();

        // long hold-off: sender keeps offering while output is blocked
        apb_write(ADDR_WIDTH, 32'd5);
        apb_write(ADDR_HEIGHT, 32'd6);
        queue_frame(5, 6, 0, PAT_RANDOM);
        hold_off_cycles = 200;
        wait_idle();

        // random frames, all small; pixels-with-noise in a few
        for (int f = 0; f < 36; f++)
        begin
            w = $urandom_range(3, 9);
            h = $urandom_range(1, 6);
            apb_write(ADDR_WIDTH, w);
            apb_write(ADDR_HEIGHT, h);
            for (int k = $urandom_range(1, 2); k > 0; k--)
                queue_frame(w, h, $urandom_range(0, 3) == 0, PAT_RANDOM);
            wait_idle();
        end

        apb_write(ADDR_HEIGHT, 32'hFFFF);
        apb_write(ADDR_WIDTH, 32'd4);
        apb_write(ADDR_HEIGHT, 32'd2);
        queue_frame(4, 2, 0, PAT_RANDOM);
        wait_idle();

        if (errors == 0 && expected_edges.size() == 0)
        begin
            $display("SUCCESS");
        end
        else
        begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule
